// File: design/mrrp_pkg.sv
// ----------------------------------------------------------------------------
// mrrp_pkg
// Shared types, codes and the CRC-16 byte update for the response parser.
// ----------------------------------------------------------------------------
package mrrp_pkg;

  localparam int READ_WORDS_DEF = 10;
  localparam int WRITE_LEN      = 8;
  localparam int OUT_FIELDS_W   = 81;
  localparam int OUT_DATA_W     = 88;

  localparam logic [7:0]  FUNC_READ     = 8'h03;
  localparam logic [7:0]  FUNC_WRITE    = 8'h06;
  localparam logic [7:0]  DEVICE_ID_RST = 8'h01;
  localparam logic [15:0] CRC_INIT      = 16'hFFFF;
  localparam logic [15:0] CRC_POLY      = 16'hA001;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_START = 2'd1;
  localparam logic [1:0] ST_LENGTH   = 2'd2;
  localparam logic [1:0] ST_CRC      = 2'd3;

  localparam logic [2:0] FC_NONE  = 3'd0;
  localparam logic [2:0] FC_READ  = 3'd3;
  localparam logic [2:0] FC_WRITE = 3'd6;

  typedef struct packed {
    logic        is_read;
    logic [1:0]  status;
    logic [2:0]  func;
    logic [7:0]  count;
    logic [15:0] addr;
    logic [15:0] value;
    logic [15:0] rx_crc;
    logic [15:0] comp_crc;
  } rep_t;

  typedef struct packed {
    logic [15:0] comp_crc;
    logic [15:0] rx_crc;
    logic [15:0] echo_addr;
    logic [15:0] word_value;
    logic [3:0]  word_index;
    logic [7:0]  byte_count;
    logic [2:0]  func;
    logic [1:0]  status;
  } out_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// File: design/mrrp_word_mem.sv
// ----------------------------------------------------------------------------
// mrrp_word_mem
// Register word store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mrrp_word_mem import mrrp_pkg::*; #(
  parameter int DEPTH = READ_WORDS_DEF,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [15:0]   wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [15:0]   rd_data
);

  logic [15:0] mem [DEPTH];
  logic [15:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: design/mrrp_frame.sv
// ----------------------------------------------------------------------------
// mrrp_frame
// Start-code hunt, frame gathering and CRC; builds the end-of-buffer report.
// ----------------------------------------------------------------------------
module mrrp_frame import mrrp_pkg::*; #(
  parameter int READ_WORDS = READ_WORDS_DEF,
  parameter int AW         = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_wr_en,
  input  logic [7:0]    cfg_wr_data,
  input  logic          acc,
  input  logic [7:0]    rx_byte,
  input  logic          eob,
  output logic          wr_en,
  output logic [AW-1:0] wr_addr,
  output logic [15:0]   wr_data,
  output logic          rep_valid,
  output rep_t          rep
);

  localparam int READ_LEN = 2 * READ_WORDS + 5;
  localparam int MAX_LEN  = (READ_LEN > WRITE_LEN) ? READ_LEN : WRITE_LEN;
  localparam int PW       = $clog2(MAX_LEN + 1);

  typedef enum logic [2:0] {
    K_HUNT  = 3'b001,
    K_READ  = 3'b010,
    K_WRITE = 3'b100
  } kind_t;

  logic [7:0]  dev_r;
  logic [7:0]  prev_r, prev_nxt;
  logic        prev_valid_r, prev_valid_nxt;
  kind_t       kind_r, kind_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  count_r, count_nxt;
  logic [7:0]  hi_r, hi_nxt;
  logic [15:0] addr_r, addr_nxt;
  logic [15:0] value_r, value_nxt;
  logic [15:0] crch_r, crch_nxt;

  logic [PW-1:0] flen, flen_nxt, off;
  logic [PW:0]   pos_w, len_w;
  logic          match, complete;

  assign flen     = (kind_r == K_READ) ? PW'(READ_LEN) : PW'(WRITE_LEN);
  assign pos_w    = {1'b0, pos_r};
  assign len_w    = {1'b0, flen};
  assign off      = pos_r - PW'(3);
  assign match    = prev_valid_r && (prev_r == dev_r) &&
                    ((rx_byte == FUNC_READ) || (rx_byte == FUNC_WRITE));
  assign wr_addr  = AW'(off >> 1);
  assign wr_data  = {hi_r, rx_byte};

  always_comb begin
    prev_nxt       = prev_r;
    prev_valid_nxt = prev_valid_r;
    kind_nxt       = kind_r;
    pos_nxt        = pos_r;
    crc_nxt        = crc_r;
    count_nxt      = count_r;
    hi_nxt         = hi_r;
    addr_nxt       = addr_r;
    value_nxt      = value_r;
    crch_nxt       = crch_r;
    wr_en          = 1'b0;

    if (acc && kind_r == K_HUNT) begin
      if (match) begin
        kind_nxt = (rx_byte == FUNC_READ) ? K_READ : K_WRITE;
        crc_nxt  = crc_byte(crc_r, rx_byte);
        pos_nxt  = PW'(2);
      end else begin
        prev_nxt       = rx_byte;
        prev_valid_nxt = 1'b1;
        crc_nxt        = crc_byte(CRC_INIT, rx_byte);
      end
    end else if (acc && pos_r < flen) begin
      if (pos_w + (PW+1)'(2) < len_w) begin
        crc_nxt = crc_byte(crc_r, rx_byte);
      end
      if (pos_w + (PW+1)'(2) == len_w) begin
        crch_nxt = {rx_byte, 8'h00};
      end else if (pos_w + (PW+1)'(1) == len_w) begin
        crch_nxt = {crch_r[15:8], rx_byte};
      end else if (kind_r == K_READ) begin
        if (pos_r == PW'(2)) begin
          count_nxt = rx_byte;
        end else if (pos_r >= PW'(3)) begin
          if (!off[0]) begin
            hi_nxt = rx_byte;
          end else begin
            wr_en = 1'b1;
          end
        end
      end else begin
        case (pos_r)
          PW'(2):  addr_nxt  = {rx_byte, 8'h00};
          PW'(3):  addr_nxt  = {addr_r[15:8], rx_byte};
          PW'(4):  value_nxt = {rx_byte, 8'h00};
          PW'(5):  value_nxt = {value_r[15:8], rx_byte};
          default: ;
        endcase
      end
      pos_nxt = pos_r + PW'(1);
    end

    flen_nxt = (kind_nxt == K_READ) ? PW'(READ_LEN) : PW'(WRITE_LEN);
    complete = (kind_nxt != K_HUNT) && (pos_nxt == flen_nxt);

    rep = '0;
    if (kind_nxt == K_HUNT) begin
      rep.status = ST_NO_START;
      rep.func   = FC_NONE;
    end else if (!complete) begin
      rep.status = ST_LENGTH;
      rep.func   = (kind_nxt == K_READ) ? FC_READ : FC_WRITE;
    end else begin
      rep.comp_crc = {crc_nxt[7:0], crc_nxt[15:8]};
      rep.rx_crc   = crch_nxt;
      rep.status   = (rep.comp_crc == crch_nxt) ? ST_OK : ST_CRC;
      if (kind_nxt == K_READ) begin
        rep.is_read = 1'b1;
        rep.func    = FC_READ;
        rep.count   = count_nxt;
      end else begin
        rep.func  = FC_WRITE;
        rep.addr  = addr_nxt;
        rep.value = value_nxt;
      end
    end
    rep_valid = acc && eob;

    if (acc && eob) begin
      prev_nxt       = '0;
      prev_valid_nxt = 1'b0;
      kind_nxt       = K_HUNT;
      pos_nxt        = '0;
      crc_nxt        = CRC_INIT;
      count_nxt      = '0;
      hi_nxt         = '0;
      addr_nxt       = '0;
      value_nxt      = '0;
      crch_nxt       = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_r        <= DEVICE_ID_RST;
      prev_r       <= '0;
      prev_valid_r <= 1'b0;
      kind_r       <= K_HUNT;
      pos_r        <= '0;
      crc_r        <= CRC_INIT;
      count_r      <= '0;
      hi_r         <= '0;
      addr_r       <= '0;
      value_r      <= '0;
      crch_r       <= '0;
    end else begin
      if (cfg_wr_en) begin
        dev_r <= cfg_wr_data;
      end
      prev_r       <= prev_nxt;
      prev_valid_r <= prev_valid_nxt;
      kind_r       <= kind_nxt;
      pos_r        <= pos_nxt;
      crc_r        <= crc_nxt;
      count_r      <= count_nxt;
      hi_r         <= hi_nxt;
      addr_r       <= addr_nxt;
      value_r      <= value_nxt;
      crch_r       <= crch_nxt;
    end
  end

  a_wr_in_read: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (kind_r == K_READ) && (pos_r >= PW'(3)) && acc)
    else $error("word write outside a read frame");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    (kind_r != K_HUNT) |-> (pos_r >= PW'(2)) && (pos_r <= flen))
    else $error("frame position out of range");

  a_hunt_crc: assert property (@(posedge clk) disable iff (!rst_n)
    (kind_r == K_HUNT) && !prev_valid_r |-> (crc_r == CRC_INIT))
    else $error("crc not at init while hunting");

endmodule

// File: design/mrrp_emit.sv
// ----------------------------------------------------------------------------
// mrrp_emit
// Result sequencer: walks the word store and feeds the output register.
// ----------------------------------------------------------------------------
module mrrp_emit import mrrp_pkg::*; #(
  parameter int READ_WORDS = READ_WORDS_DEF,
  parameter int AW         = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          rep_valid,
  input  rep_t          rep,
  output logic          busy,
  output logic          rd_en,
  output logic [AW-1:0] rd_addr,
  input  logic [15:0]   rd_data,
  output logic          out_valid,
  input  logic          out_ready,
  output out_t          out_data,
  output logic          out_last
);

  typedef enum logic [3:0] {
    E_IDLE   = 4'b0001,
    E_SINGLE = 4'b0010,
    E_READ   = 4'b0100,
    E_LOAD   = 4'b1000
  } emit_t;

  emit_t         state_r, state_nxt;
  rep_t          rep_r;
  logic [AW-1:0] idx_r, idx_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_t          out_data_r, out_data_nxt;
  logic          out_last_r, out_last_nxt;
  logic          out_free, load, idx_end;

  assign out_free = !out_valid_r || out_ready;
  assign idx_end  = (idx_r == AW'(READ_WORDS - 1));
  assign rd_addr  = idx_r;

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    rd_en         = 1'b0;
    load          = 1'b0;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r && !out_ready;

    out_data_nxt.status     = rep_r.status;
    out_data_nxt.func       = rep_r.func;
    out_data_nxt.byte_count = rep_r.count;
    out_data_nxt.echo_addr  = rep_r.addr;
    out_data_nxt.rx_crc     = rep_r.rx_crc;
    out_data_nxt.comp_crc   = rep_r.comp_crc;

    case (state_r)
      E_IDLE: begin
        if (rep_valid) begin
          idx_nxt   = '0;
          state_nxt = rep.is_read ? E_READ : E_SINGLE;
        end
      end
      E_SINGLE: begin
        if (out_free) begin
          load                    = 1'b1;
          out_data_nxt.word_index = '0;
          out_data_nxt.word_value = rep_r.value;
          out_last_nxt            = 1'b1;
          state_nxt               = E_IDLE;
        end
      end
      E_READ: begin
        if (out_free) begin
          rd_en     = 1'b1;
          state_nxt = E_LOAD;
        end
      end
      E_LOAD: begin
        load                    = 1'b1;
        out_data_nxt.word_index = 4'(idx_r);
        out_data_nxt.word_value = rd_data;
        out_last_nxt            = idx_end;
        if (idx_end) begin
          state_nxt = E_IDLE;
        end else begin
          idx_nxt   = idx_r + AW'(1);
          state_nxt = E_READ;
        end
      end
      default: state_nxt = E_IDLE;
    endcase

    if (load) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_data_nxt = out_data_r;
      out_last_nxt = out_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= E_IDLE;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == E_IDLE && rep_valid) begin
      rep_r <= rep;
    end
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  assign busy      = (state_r != E_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_last  = out_last_r;

  a_load_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == E_LOAD) |-> $past(rd_en))
    else $error("word load without a prior read");

  a_load_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> out_free)
    else $error("output register overwritten");

  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (load && out_last_nxt) |=> (state_r == E_IDLE))
    else $error("run continues after last result");

endmodule

// File: design/modbus_rtu_response_parser.sv
// ----------------------------------------------------------------------------
// modbus_rtu_response_parser
// Modbus RTU response parser with CRC-16 check, stream in and stream out.
// ----------------------------------------------------------------------------
// Input: one received byte per transfer on in_tdata, in_tlast on the last
// byte of a receive buffer. Output: result items on out_*, out_tlast on the
// final result of a run. The unit address is set through
// cfg_wr_en/cfg_wr_data; the user must write it only while idle, which the
// block does not enforce; reset value 1. A byte that is not the end of a
// buffer produces nothing. On the end-of-buffer byte a report is built in the
// same cycle; a single result is then loaded into the output register in
// state E_SINGLE, each word of a read response by a read in E_READ and a load
// in E_LOAD. A write echo, a missing start code or a short frame gives one
// result; a completed read response, good or bad CRC, gives READ_WORDS results
// through the word store's registered read port. in_tready is low from the
// end-of-buffer transfer until the last result is in the output register, so
// the next buffer may start while that result still waits. A stalled receiver
// holds the output register and the word walk. Synchronous reset returns to
// hunting with CRC 0xFFFF; the word store needs no clearing pass.
// ----------------------------------------------------------------------------
module modbus_rtu_response_parser import mrrp_pkg::*; #(
  parameter int READ_WORDS = READ_WORDS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [7:0]            cfg_wr_data,   // unit address
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,      // rx_byte
  input  logic                  in_tlast,      // end_of_buffer
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // status[1:0], fn_code[4:2], byte_count[12:5], word_index[16:13],
  // word_value[32:17], echo_address[48:33], received_crc[64:49],
  // computed_crc[80:65], zero pad[87:81]
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast      // last
);

  localparam int AW = (READ_WORDS > 1) ? $clog2(READ_WORDS) : 1;

  logic          acc, busy;
  logic          wr_en, rd_en, rep_valid;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [15:0]   wr_data, rd_data;
  rep_t          rep;
  out_t          out_data;

  assign in_tready = !busy;
  assign acc       = in_tvalid && !busy;
  assign out_tdata = {(OUT_DATA_W - OUT_FIELDS_W)'(0), out_data};

  mrrp_frame #(
    .READ_WORDS (READ_WORDS),
    .AW         (AW)
  ) u_frame (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .acc         (acc),
    .rx_byte     (in_tdata),
    .eob         (in_tlast),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .rep_valid   (rep_valid),
    .rep         (rep)
  );

  mrrp_word_mem #(
    .DEPTH (READ_WORDS),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  mrrp_emit #(
    .READ_WORDS (READ_WORDS),
    .AW         (AW)
  ) u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .rep_valid (rep_valid),
    .rep       (rep),
    .busy      (busy),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_data),
    .out_last  (out_tlast)
  );

endmodule

// File: tb/sv/mrrp_frame_checker.sv
// ----------------------------------------------------------------------------
// mrrp_frame_checker
// Watches the byte stream, the device id writes and the result stream of the
// response parser. Keeps its own model of the hunt, the frame gathering and the
// CRC-16. Each byte transfer may queue expected results, and each result
// transfer is compared field by field against the oldest one.
// ----------------------------------------------------------------------------
module mrrp_frame_checker import mrrp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [7:0]            cfg_wr_data,   // unit address
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [7:0]            in_tdata,      // rx_byte
  input  logic                  in_tlast,      // end_of_buffer
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  output int                    mismatches,
  output int                    backlog,
  output int                    results_checked,
  output int                    frames_ok,
  output int                    frames_crc_bad,
  output int                    frames_short,
  output int                    buffers_unmatched,
  // status[1:0], fn_code[4:2], byte_count[12:5], word_index[16:13],
  // word_value[32:17], echo_address[48:33], received_crc[64:49],
  // computed_crc[80:65], zero pad[87:81]
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  out_tlast      // last
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int READ_LEN = 2 * READ_WORDS_DEF + 5;

  typedef enum logic [1:0] {HUNTING, IN_READ, IN_WRITE} frame_e;

  typedef struct packed {
    out_t f;
    logic last;
  } result_t;

  result_t     reply_q[$];
  logic [7:0]  dev_id = DEVICE_ID_RST;
  logic [7:0]  last_byte;
  logic        last_ok;
  frame_e      frame;
  int          taken;
  logic [15:0] crc_run;
  logic [7:0]  count_byte;
  logic [7:0]  word_hi;
  logic [15:0] words [READ_WORDS_DEF];
  logic [15:0] echo_addr;
  logic [15:0] echo_val;
  logic [15:0] crc_rx;
  int          errs = 0;
  int          checked = 0;
  int          n_ok = 0;
  int          n_crc = 0;
  int          n_short = 0;
  int          n_none = 0;

  // Modbus CRC-16, reflected polynomial, one byte
  function automatic logic [15:0] crc16_next(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (r[0]) begin
        r = {1'b0, r[15:1]} ^ 16'hA001;
      end else begin
        r = {1'b0, r[15:1]};
      end
    end
    return r;
  endfunction

  function automatic int frame_bytes();
    return (frame == IN_READ) ? READ_LEN : WRITE_LEN;
  endfunction

  task automatic restart_frame();
    last_byte  = 8'h00;
    last_ok    = 1'b0;
    frame      = HUNTING;
    taken      = 0;
    crc_run    = 16'hFFFF;
    count_byte = 8'h00;
    word_hi    = 8'h00;
    echo_addr  = 16'h0000;
    echo_val   = 16'h0000;
    crc_rx     = 16'h0000;
  endtask

  task automatic take_rx_byte(input logic [7:0] b, input logic eob);
    int          flen;
    logic [15:0] swapped;
    logic [1:0]  st;
    result_t     r;
    if (frame == HUNTING) begin
      if (last_ok && last_byte == dev_id && (b == FUNC_READ || b == FUNC_WRITE)) begin
        frame   = (b == FUNC_READ) ? IN_READ : IN_WRITE;
        crc_run = crc16_next(crc16_next(crc_run, last_byte), b);
        taken   = 2;
      end else begin
        last_byte = b;
        last_ok   = 1'b1;
      end
    end else if (taken < frame_bytes()) begin
      flen = frame_bytes();
      if (taken + 2 < flen) crc_run = crc16_next(crc_run, b);
      if (taken + 2 == flen) begin
        crc_rx = {b, 8'h00};
      end else if (taken + 1 == flen) begin
        crc_rx[7:0] = b;
      end else if (frame == IN_READ) begin
        if (taken == 2) begin
          count_byte = b;
        end else if ((taken - 3) % 2 == 0) begin
          word_hi = b;
        end else begin
          words[(taken - 3) / 2] = {word_hi, b};
        end
      end else begin
        case (taken)
          2: echo_addr[15:8] = b;
          3: echo_addr[7:0]  = b;
          4: echo_val[15:8]  = b;
          5: echo_val[7:0]   = b;
          default: ;
        endcase
      end
      taken++;
    end

    if (!eob) return;

    swapped = {crc_run[7:0], crc_run[15:8]};
    r = '0;
    r.last = 1'b1;
    if (frame == HUNTING) begin
      r.f.status = ST_NO_START;
      r.f.func   = FC_NONE;
      reply_q.push_back(r);
      n_none++;
    end else if (taken < frame_bytes()) begin
      r.f.status = ST_LENGTH;
      r.f.func   = (frame == IN_READ) ? FC_READ : FC_WRITE;
      reply_q.push_back(r);
      n_short++;
    end else begin
      st = (swapped == crc_rx) ? ST_OK : ST_CRC;
      if (st == ST_OK) n_ok++;
      else n_crc++;
      r.f.status   = st;
      r.f.rx_crc   = crc_rx;
      r.f.comp_crc = swapped;
      if (frame == IN_READ) begin
        r.f.func       = FC_READ;
        r.f.byte_count = count_byte;
        for (int k = 0; k < READ_WORDS_DEF; k++) begin
          r.f.word_index = 4'(k);
          r.f.word_value = words[k];
          r.last         = (k == READ_WORDS_DEF - 1);
          reply_q.push_back(r);
        end
      end else begin
        r.f.func       = FC_WRITE;
        r.f.word_value = echo_val;
        r.f.echo_addr  = echo_addr;
        reply_q.push_back(r);
      end
    end
    restart_frame();
  endtask

  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
    if (want !== got) begin
      errs++;
      if (errs <= 10) begin
        $display("[%0t] result %0d: %s expected 0x%0h, got 0x%0h",
                 $time, checked, name, want, got);
      end
    end
  endtask

  task automatic check_reply();
    out_t    got;
    result_t want;
    got = out_tdata[OUT_FIELDS_W-1:0];
    if (reply_q.size() == 0) begin
      errs++;
      if (errs <= 10) begin
        $display("[%0t] result %0d: none expected, got 0x%0h last %0b",
                 $time, checked, out_tdata, out_tlast);
      end
    end else begin
      want = reply_q.pop_front();
      compare_field("status", 16'(want.f.status), 16'(got.status));
      compare_field("fn_code", 16'(want.f.func), 16'(got.func));
      compare_field("byte_count", 16'(want.f.byte_count), 16'(got.byte_count));
      compare_field("word_index", 16'(want.f.word_index), 16'(got.word_index));
      compare_field("word_value", want.f.word_value, got.word_value);
      compare_field("echo_address", want.f.echo_addr, got.echo_addr);
      compare_field("received_crc", want.f.rx_crc, got.rx_crc);
      compare_field("computed_crc", want.f.comp_crc, got.comp_crc);
      compare_field("last", 16'(want.last), 16'(out_tlast));
      compare_field("padding", 16'h0000, 16'(out_tdata[OUT_DATA_W-1:OUT_FIELDS_W]));
    end
    checked++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      dev_id = DEVICE_ID_RST;
      reply_q.delete();
      restart_frame();
    end else begin
      if (out_tvalid && out_tready) check_reply();
      if (cfg_wr_en) dev_id = cfg_wr_data;
      if (in_tvalid && in_tready) take_rx_byte(in_tdata, in_tlast);
    end
    mismatches        <= errs;
    backlog           <= reply_q.size();
    results_checked   <= checked;
    frames_ok         <= n_ok;
    frames_crc_bad    <= n_crc;
    frames_short      <= n_short;
    buffers_unmatched <= n_none;
  end

endmodule

// File: tb/sv/modbus_rtu_response_parser_test.sv
// ----------------------------------------------------------------------------
// modbus_rtu_response_parser_test
// Drives receive buffers into the response parser: a few directed buffers,
// then mostly well-formed read and write frames with random content, corrupted
// and truncated frames, and noise, under several device ids. The sender works
// in bursts and the receiver stalls, with one long hold-off. mrrp_frame_checker
// predicts and compares the results, and this module gives the verdict.
// ----------------------------------------------------------------------------
module modbus_rtu_response_parser_test;
  timeunit 1ns;
  timeprecision 1ps;
  import mrrp_pkg::*;

  localparam int READ_LEN     = 2 * READ_WORDS_DEF + 5;
  localparam int TARGET_BYTES = 250;
  localparam int DRAIN        = 8;
  localparam int HOLD_CYCLES  = 300;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [7:0]            cfg_wr_data = 8'h00;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata = 8'h00;
  logic                  in_tlast = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;

  int mismatches, backlog, results_checked;
  int frames_ok, frames_crc_bad, frames_short, buffers_unmatched;

  logic [7:0] frame_q[$];
  logic [7:0] cur_id = DEVICE_ID_RST;
  int         burst_left = 0;
  int         bytes_sent = 0;
  int         buffers_sent = 0;
  int         id_writes = 0;
  bit         hold_go = 1'b0;

  always #10 clk = ~clk;

  modbus_rtu_response_parser dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  mrrp_frame_checker frame_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_tvalid        (in_tvalid),
    .in_tready        (in_tready),
    .in_tdata         (in_tdata),
    .in_tlast         (in_tlast),
    .out_tvalid       (out_tvalid),
    .out_tready       (out_tready),
    .mismatches       (mismatches),
    .backlog          (backlog),
    .results_checked  (results_checked),
    .frames_ok        (frames_ok),
    .frames_crc_bad   (frames_crc_bad),
    .frames_short     (frames_short),
    .buffers_unmatched(buffers_unmatched),
    .out_tdata        (out_tdata),
    .out_tlast        (out_tlast)
  );

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic eob);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    burst_left--;
    in_tdata  <= b;
    in_tlast  <= eob;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_frame();
    for (int k = 0; k < frame_q.size(); k++) begin
      push_byte(frame_q[k], k == frame_q.size() - 1);
    end
    frame_q.delete();
    buffers_sent++;
  endtask

  // wait until every expected result has come out and the block is quiet
  task automatic settle();
    in_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (backlog != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_id(input logic [7:0] v);
    settle();
    cfg_wr_data <= v;
    cfg_wr_en   <= 1'b1;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_id = v;
    id_writes++;
  endtask

  task automatic add_junk(input int n);
    repeat (n) frame_q.push_back(rand_byte());
  endtask

  // CRC over the last n bytes, sent low byte first
  task automatic seal_frame(input int n);
    logic [15:0] crc;
    crc = CRC_INIT;
    for (int k = frame_q.size() - n; k < frame_q.size(); k++) crc = crc_byte(crc, frame_q[k]);
    frame_q.push_back(crc[7:0]);
    frame_q.push_back(crc[15:8]);
  endtask

  task automatic add_read(input logic [7:0] id, input logic [7:0] count);
    frame_q.push_back(id);
    frame_q.push_back(FUNC_READ);
    frame_q.push_back(count);
    add_junk(2 * READ_WORDS_DEF);
    seal_frame(READ_LEN - 2);
  endtask

  task automatic add_write(input logic [7:0] id, input logic [15:0] addr,
                           input logic [15:0] value);
    frame_q.push_back(id);
    frame_q.push_back(FUNC_WRITE);
    frame_q.push_back(addr[15:8]);
    frame_q.push_back(addr[7:0]);
    frame_q.push_back(value[15:8]);
    frame_q.push_back(value[7:0]);
    seal_frame(WRITE_LEN - 2);
  endtask

  // flip one bit past the function code of the frame at the tail
  task automatic corrupt_tail(input int flen);
    int idx;
    idx = frame_q.size() - $urandom_range(1, flen - 2);
    frame_q[idx] = frame_q[idx] ^ (8'h01 << $urandom_range(0, 7));
  endtask

  task automatic build_random_buffer();
    int         pick;
    int         flen;
    logic [7:0] dropped;
    logic [7:0] other_id;
    if ($urandom_range(0, 3) == 0) add_junk($urandom_range(1, 3));
    pick = $urandom_range(0, 99);
    if (pick >= 90) begin
      other_id = cur_id + 8'd1;
      if (pick < 95) add_junk($urandom_range(1, 10));
      else add_write(other_id, {rand_byte(), rand_byte()}, {rand_byte(), rand_byte()});
    end else begin
      if ($urandom_range(0, 1) == 1) begin
        flen = READ_LEN;
        add_read(cur_id, ($urandom_range(0, 3) == 0) ? rand_byte() : 8'(2 * READ_WORDS_DEF));
      end else begin
        flen = WRITE_LEN;
        add_write(cur_id, {rand_byte(), rand_byte()}, {rand_byte(), rand_byte()});
      end
      if (pick >= 75) begin
        repeat ($urandom_range(1, flen - 2)) dropped = frame_q.pop_back();
      end else begin
        if (pick >= 60) corrupt_tail(flen);
        if ($urandom_range(0, 3) == 0) add_junk($urandom_range(1, 3));
      end
    end
  endtask

  initial begin : sink
    int mode;
    int span;
    int k;
    forever begin
      if (hold_go) begin
        hold_go = 1'b0;
        out_tready <= 1'b0;
        for (k = 0; k < HOLD_CYCLES; k++) @(posedge clk);
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(10, 60);
      for (k = 0; k < span; k++) begin
        case (mode)
          0: out_tready <= 1'b1;
          1: out_tready <= 1'($urandom_range(0, 1));
          2: out_tready <= ($urandom_range(0, 3) == 0);
          default: out_tready <= (k % 3 != 2);
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    logic [7:0] next_id;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // good write echo with extreme address and value
    add_write(DEVICE_ID_RST, 16'h0000, 16'hFFFF);
    send_frame();
    // junk lead byte, then a write echo with a damaged byte
    frame_q.push_back(8'hFF);
    add_write(DEVICE_ID_RST, 16'h1234, 16'h0000);
    corrupt_tail(WRITE_LEN);
    send_frame();
    // start pair on the last byte: read too short
    frame_q.push_back(DEVICE_ID_RST);
    frame_q.push_back(FUNC_READ);
    send_frame();
    // one-byte buffer, no start code
    frame_q.push_back(8'h00);
    send_frame();
    // start pair split over two buffers does not count
    frame_q.push_back(DEVICE_ID_RST);
    send_frame();
    frame_q.push_back(FUNC_WRITE);
    frame_q.push_back(8'h00);
    send_frame();
    // repeated id before the function code: write too short
    frame_q.push_back(DEVICE_ID_RST);
    frame_q.push_back(DEVICE_ID_RST);
    frame_q.push_back(FUNC_WRITE);
    send_frame();

    while (bytes_sent < TARGET_BYTES) begin
      if (buffers_sent % 4 == 3) begin
        case (id_writes % 6)
          0: next_id = 8'h00;
          1: next_id = 8'hFF;
          2: next_id = FUNC_READ;
          3: next_id = FUNC_WRITE;
          4: next_id = 8'($urandom_range(0, 255));
          default: next_id = DEVICE_ID_RST;
        endcase
        write_id(next_id);
      end
      if (buffers_sent == 10) hold_go = 1'b1;
      build_random_buffer();
      send_frame();
    end

    settle();
    $display("Sent %0d buffers (%0d bytes) under %0d device id settings; %0d results checked.",
             buffers_sent, bytes_sent, id_writes + 1, results_checked);
    $display("Reports: %0d good, %0d bad CRC, %0d too short, %0d without a start code.",
             frames_ok, frames_crc_bad, frames_short, buffers_unmatched);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
